// File: sv/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg - shared types and constants of the periodic task tick scheduler
// Slot count, field widths, result codes, command and result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

	// number of task slots (1 to 64)
	localparam int NUM_TASKS = 8;
	localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W     = 8;
	localparam int TIDX_W    = 6;
	localparam int ENT_W     = 2 * CNT_W;

	// command opcodes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_CREATE = 1'b1;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FIRE   = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SLOT = 2'd1,
		ST_TAKEN    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_END
	} state_t;

	typedef struct packed {
		logic             opcode;
		logic [7:0]       slot;
		logic [CNT_W-1:0] period;
		logic [CNT_W-1:0] first_delay;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		status_t           status;
		logic [TIDX_W-1:0] task_index;
		logic              last;
	} res_t;

	// sequencer to datapath control
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             s1_vld;
		logic [IDX_W-1:0] s1_idx;
		logic             end_tick;
	} seq_ctl_t;

endpackage

`default_nettype wire

// File: sv/ptts_ram.sv
// ----------------------------------------------------------------------------
// ptts_ram - simple dual port synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/ptts_seq.sv
// ----------------------------------------------------------------------------
// ptts_seq - tick walk sequencer
// Steps the slot index through the table, one read per cycle, and tracks
// the read-to-update stage and the end-of-tick transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                opcode,
	output logic                     busy,
	output ptts_pkg::seq_ctl_t       ctl
);

	ptts_pkg::state_t               state_q, state_d;
	logic [ptts_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic                           s1_vld_s1;
	logic [ptts_pkg::IDX_W-1:0]     s1_idx_s1;
	logic                           rd_en;
	logic                           end_tick;

	// state and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptts_pkg::S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		rd_en    = 1'b0;
		busy     = 1'b1;
		end_tick = 1'b0;
		case (state_q)
			ptts_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start && opcode == ptts_pkg::OP_TICK) begin
					state_d = ptts_pkg::S_WALK;
					idx_d   = '0;
				end
			end
			ptts_pkg::S_WALK: begin
				rd_en = 1'b1;
				if (idx_q == ptts_pkg::IDX_W'(ptts_pkg::NUM_TASKS - 1)) begin
					state_d = ptts_pkg::S_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ptts_pkg::S_DRAIN: begin
				state_d = ptts_pkg::S_END;
			end
			ptts_pkg::S_END: begin
				end_tick = 1'b1;
				state_d  = ptts_pkg::S_IDLE;
			end
			default: begin
				state_d = ptts_pkg::S_IDLE;
			end
		endcase
	end

	// read-to-update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
			s1_idx_s1 <= '0;
		end else begin
			s1_vld_s1 <= rd_en;
			s1_idx_s1 <= idx_q;
		end
	end

	assign ctl.rd_en    = rd_en;
	assign ctl.rd_idx   = idx_q;
	assign ctl.s1_vld   = s1_vld_s1;
	assign ctl.s1_idx   = s1_idx_s1;
	assign ctl.end_tick = end_tick;

endmodule

`default_nettype wire

// File: sv/periodic_task_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit - time-triggered cooperative scheduler
// Task slot table with create and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low. Create (opcode 1) checks the slot and answers with one status
//   result on the following cycle; busy stays low, so commands may follow
//   every cycle. Tick (opcode 0) walks all NUM_TASKS slots in ascending
//   order, one RAM read per cycle, and updates each used slot in the cycle after
//   its read. Each firing slot gives a fire result, and an end-of-tick result
//   with last set closes the tick. A tick holds busy through the walk, drain and
//   end states; the walk length is set by the single read port of the slot RAM.
//   Results appear on result for one cycle, marked by strobe, in the cycle after
//   their create, slot update or end state. The receiver cannot stall them.
//   Reset clears the slot-used flags and the sequencer; periods and
//   countdowns sit in RAM and are written by the create that claims a slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_tick_scheduler_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ptts_pkg::cmd_t cmd,
	output logic                busy,
	output logic                strobe,
	output ptts_pkg::res_t      result
);

	ptts_pkg::seq_ctl_t                 ctl;
	logic [ptts_pkg::NUM_TASKS-1:0]     used_q;
	logic                               create;
	logic                               slot_ok;
	logic [ptts_pkg::IDX_W-1:0]         slot_idx;
	logic                               create_ok;
	ptts_pkg::status_t                  create_st;
	logic                               wr_en;
	logic [ptts_pkg::IDX_W-1:0]         wr_addr;
	logic [ptts_pkg::ENT_W-1:0]         wr_data;
	logic [ptts_pkg::ENT_W-1:0]         rd_data;
	logic [ptts_pkg::CNT_W-1:0]         cd;
	logic [ptts_pkg::CNT_W-1:0]         per;
	logic                               s1_live;
	logic                               fire;
	logic                               strobe_q;
	ptts_pkg::res_t                     result_q;

	ptts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (cmd.opcode),
		.busy   (busy),
		.ctl    (ctl)
	);

	// create check
	assign create   = start && !busy && cmd.opcode == ptts_pkg::OP_CREATE;
	assign slot_ok  = cmd.slot < 8'(ptts_pkg::NUM_TASKS);
	assign slot_idx = cmd.slot[ptts_pkg::IDX_W-1:0];

	always_comb begin
		if (!slot_ok) begin
			create_st = ptts_pkg::ST_BAD_SLOT;
		end else if (used_q[slot_idx]) begin
			create_st = ptts_pkg::ST_TAKEN;
		end else begin
			create_st = ptts_pkg::ST_OK;
		end
	end

	assign create_ok = create && create_st == ptts_pkg::ST_OK;

	// slot-used flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (create_ok) begin
			used_q[slot_idx] <= 1'b1;
		end
	end

	// slot update: entry is {period, countdown}
	assign per     = rd_data[ptts_pkg::ENT_W-1:ptts_pkg::CNT_W];
	assign cd      = rd_data[ptts_pkg::CNT_W-1:0];
	assign s1_live = ctl.s1_vld && used_q[ctl.s1_idx];
	assign fire    = s1_live && cd == '0;

	// RAM write mux; create only runs while no walk is in flight
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ctl.s1_idx;
		wr_data = {per, per};
		if (create_ok) begin
			wr_en   = 1'b1;
			wr_addr = slot_idx;
			wr_data = {cmd.period, cmd.first_delay};
		end else if (s1_live) begin
			wr_en = 1'b1;
			if (cd != '0) begin
				wr_data = {per, cd - 1'b1};
			end
		end
	end

	ptts_ram #(
		.DEPTH (ptts_pkg::NUM_TASKS),
		.WIDTH (ptts_pkg::ENT_W),
		.AW    (ptts_pkg::IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (ctl.rd_idx),
		.rd_data (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= create || fire || ctl.end_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (create) begin
			result_q.kind       <= ptts_pkg::KIND_STATUS;
			result_q.status     <= create_st;
			result_q.task_index <= '0;
			result_q.last       <= 1'b1;
		end else if (fire) begin
			result_q.kind       <= ptts_pkg::KIND_FIRE;
			result_q.status     <= ptts_pkg::ST_OK;
			result_q.task_index <= ptts_pkg::TIDX_W'(ctl.s1_idx);
			result_q.last       <= 1'b0;
		end else if (ctl.end_tick) begin
			result_q.kind       <= ptts_pkg::KIND_END;
			result_q.status     <= ptts_pkg::ST_OK;
			result_q.task_index <= '0;
			result_q.last       <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// create never overlaps a walk update
	a_create_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		create |-> !ctl.s1_vld && !ctl.end_tick)
		else $error("create during tick walk");

	// create answers with one status result on the next cycle
	a_create_status: assert property (@(posedge clk) disable iff (!arst_n)
		create |=> strobe && result.kind == ptts_pkg::KIND_STATUS && result.last)
		else $error("create status missing");

	// end of tick gives a last result
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.end_tick |=> strobe && result.kind == ptts_pkg::KIND_END && result.last)
		else $error("end-of-tick result missing");

	// fire results never close a transaction
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == ptts_pkg::KIND_FIRE |-> !result.last)
		else $error("fire result marked last");

	// walk activity only while busy
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en || ctl.s1_vld |-> busy)
		else $error("walk while not busy");

endmodule

`default_nettype wire
